>>> rtl/e2q_pkg.sv
package e2q_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

   localparam int NUM_AXES   = 3;
   localparam int NUM_COMP   = 4;
   localparam int AXIS_ROLL  = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_YAW   = 2;

   localparam int XY_W       = 32;
   localparam int Z_W        = 34;
   localparam int ATAN_W     = 30;
   localparam int CS_W       = 18;
   localparam int M1_W       = 36;
   localparam int A_W        = 22;
   localparam int M2_W       = 40;
   localparam int COMP_W     = 32;
   localparam int SQ_W       = 64;
   localparam int SQRT_STEPS = 32;
   localparam int ROOT_W     = 32;
   localparam int Q_W        = 16;
   localparam int DIV_STEPS  = Q_W;
   localparam int REM_W      = 48;

   localparam logic signed [XY_W-1:0] X_START = 32'sd268435456;
   localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [Q_W-1:0]         ONE_Q14     = 16'd16384;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } cordic_lane_type;

   typedef struct packed {
      logic                                 valid;
      cordic_lane_type [NUM_AXES-1:0]       lane;
   } cordic_word_type;

   typedef struct packed {
      logic                                 valid;
      logic [SQ_W-1:0]                      n;
      logic [SQ_W-1:0]                      res;
      logic [NUM_COMP-1:0][COMP_W-1:0]      comp;
   } sqrt_word_type;

   typedef struct packed {
      logic                                 valid;
      logic [ROOT_W-1:0]                    r;
      logic [NUM_COMP-1:0][REM_W-1:0]       rem;
      logic [NUM_COMP-1:0][Q_W-1:0]         q;
      logic [NUM_COMP-1:0]                  neg;
   } div_word_type;

   // atan(2^-i) in units of 2^-30 rad, truncated
   function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 30'h3243F6A8;
         5'd1:    v = 30'h1DAC6705;
         5'd2:    v = 30'h0FADBAFC;
         5'd3:    v = 30'h07F56EA6;
         5'd4:    v = 30'h03FEAB76;
         5'd5:    v = 30'h01FFD55B;
         5'd6:    v = 30'h00FFFAAA;
         5'd7:    v = 30'h007FFF55;
         5'd8:    v = 30'h003FFFEA;
         5'd9:    v = 30'h001FFFFD;
         5'd10:   v = 30'h000FFFFF;
         5'd11:   v = 30'h0007FFFF;
         5'd12:   v = 30'h0003FFFF;
         5'd13:   v = 30'h0001FFFF;
         5'd14:   v = 30'h0000FFFF;
         5'd15:   v = 30'h00007FFF;
         5'd16:   v = 30'h00003FFF;
         5'd17:   v = 30'h00001FFF;
         5'd18:   v = 30'h00000FFF;
         5'd19:   v = 30'h000007FF;
         5'd20:   v = 30'h000003FF;
         5'd21:   v = 30'h000001FF;
         5'd22:   v = 30'h000000FF;
         5'd23:   v = 30'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/e2q_cordic_cell.sv
module e2q_cordic_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic [4:0]               step,
   input  e2q_pkg::cordic_word_type in_word,
   output e2q_pkg::cordic_word_type out_word
);
   import e2q_pkg::*;

   cordic_word_type word_ff, word_in;

   always_comb begin
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  da;
      word_in = in_word;
      da = signed'(Z_W'(atan_q30(step)));
      for (int l = 0; l < NUM_AXES; l++) begin
         dx = in_word.lane[l].y >>> step;
         dy = in_word.lane[l].x >>> step;
         if (!in_word.lane[l].z[Z_W-1]) begin
            word_in.lane[l].x = in_word.lane[l].x - dx;
            word_in.lane[l].y = in_word.lane[l].y + dy;
            word_in.lane[l].z = in_word.lane[l].z - da;
         end else begin
            word_in.lane[l].x = in_word.lane[l].x + dx;
            word_in.lane[l].y = in_word.lane[l].y - dy;
            word_in.lane[l].z = in_word.lane[l].z + da;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (adv) begin
         word_ff <= word_in;
      end
   end

   assign out_word = word_ff;

endmodule

>>> rtl/e2q_sqrt_cell.sv
module e2q_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [4:0]             step,
   input  e2q_pkg::sqrt_word_type in_word,
   output e2q_pkg::sqrt_word_type out_word
);
   import e2q_pkg::*;

   sqrt_word_type word_ff, word_in;

   // one result bit per cell, trial bit walks down by two places
   always_comb begin
      logic [SQ_W-1:0] bitv;
      logic [SQ_W-1:0] t;
      word_in = in_word;
      bitv = SQ_W'(1) << (6'd62 - {step, 1'b0});
      t = in_word.res + bitv;
      if (in_word.n >= t) begin
         word_in.n   = in_word.n - t;
         word_in.res = (in_word.res >> 1) + bitv;
      end else begin
         word_in.res = in_word.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (adv) begin
         word_ff <= word_in;
      end
   end

   assign out_word = word_ff;

endmodule

>>> rtl/e2q_div_cell.sv
module e2q_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic [3:0]            step,
   input  e2q_pkg::div_word_type in_word,
   output e2q_pkg::div_word_type out_word
);
   import e2q_pkg::*;

   div_word_type word_ff, word_in;

   always_comb begin
      logic [REM_W-1:0] dsh;
      word_in = in_word;
      dsh = REM_W'(in_word.r) << step;
      for (int l = 0; l < NUM_COMP; l++) begin
         if (in_word.rem[l] >= dsh) begin
            word_in.rem[l] = in_word.rem[l] - dsh;
            word_in.q[l]   = in_word.q[l] | (Q_W'(1) << step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (adv) begin
         word_ff <= word_in;
      end
   end

   assign out_word = word_ff;

endmodule

>>> rtl/euler_to_quaternion.sv
// Euler angles to unit quaternion.
// req channel: one word carries roll, pitch and yaw in signed Q3.13 radians.
// rsp channel: one word per request with w, x, y, z in signed Q2.14, within
// plus or minus one, in request order.
// Pipeline: one fold stage, CORDIC_N CORDIC cells (all three axes side by
// side), seven product and square stages, 32 square-root cells, one divide
// setup stage, 16 restoring-divide cells and the output register.
// Throughput is one word per cycle while the skid register is empty.
// A skid register behind the output register takes one word when rsp_stall
// is high; only while it is full does the whole pipeline hold and req_stall
// rise. req_stall is a register output.
// Reset clears every valid bit; the block accepts words in the next cycle.
module euler_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  e2q_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output e2q_pkg::rsp_type rsp_word
);
   import e2q_pkg::*;

   logic adv;

   cordic_word_type fold_ff, fold_in;
   cordic_word_type cchain [CORDIC_N+1];

   logic [6:0] pv_ff, pv_in;
   logic signed [CS_W-1:0]   cs_c_ff [NUM_AXES], cs_c_in [NUM_AXES];
   logic signed [CS_W-1:0]   cs_s_ff [NUM_AXES], cs_s_in [NUM_AXES];
   logic signed [M1_W-1:0]   m1_ff [4], m1_in [4];
   logic signed [CS_W-1:0]   p2_cp_ff, p2_sp_ff;
   logic signed [M2_W-1:0]   m2_ff [8], m2_in [8];
   logic signed [COMP_W-1:0] comp4_ff [NUM_COMP], comp4_in [NUM_COMP];
   logic [COMP_W-1:0]        comp5_ff [NUM_COMP], comp6_ff [NUM_COMP];
   logic [COMP_W-1:0]        comp7_ff [NUM_COMP];
   logic [SQ_W-1:0]          sq_ff [NUM_COMP], sq_in [NUM_COMP];
   logic [SQ_W-1:0]          s01_ff, s23_ff, sum_ff;

   sqrt_word_type schain [SQRT_STEPS+1];
   div_word_type  div0_ff, div0_in;
   div_word_type  dchain [DIV_STEPS+1];

   logic    rsp_valid_ff, skid_vld_ff;
   rsp_type rsp_word_ff, skid_word_ff, fin_word;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // fold the half angle into [-pi/2, pi/2]
   always_comb begin
      logic signed [15:0]    ang [NUM_AXES];
      logic signed [Z_W-1:0] z;
      ang[AXIS_ROLL]  = req_word.roll;
      ang[AXIS_PITCH] = req_word.pitch;
      ang[AXIS_YAW]   = req_word.yaw;
      fold_in.valid = req_valid;
      for (int a = 0; a < NUM_AXES; a++) begin
         z = signed'({{2{ang[a][15]}}, ang[a], 16'b0});
         fold_in.lane[a].x    = X_START;
         fold_in.lane[a].y    = '0;
         fold_in.lane[a].flip = 1'b0;
         if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            fold_in.lane[a].flip = 1'b1;
         end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            fold_in.lane[a].flip = 1'b1;
         end
         fold_in.lane[a].z = z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff.valid <= 1'b0;
      end else if (adv) begin
         fold_ff <= fold_in;
      end
   end

   assign cchain[0] = fold_ff;

   for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
      e2q_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (5'(g)),
         .in_word  (cchain[g]),
         .out_word (cchain[g+1])
      );
   end

   // cos/sin, products and sum of squares
   always_comb begin
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [A_W-1:0]  av [4];
      logic [COMP_W-1:0]      mag;
      pv_in = {pv_ff[5:0], cchain[CORDIC_N].valid};
      for (int a = 0; a < NUM_AXES; a++) begin
         xs = cchain[CORDIC_N].lane[a].x >>> 14;
         ys = cchain[CORDIC_N].lane[a].y >>> 14;
         if (cchain[CORDIC_N].lane[a].flip) begin
            xs = -xs;
            ys = -ys;
         end
         cs_c_in[a] = xs[CS_W-1:0];
         cs_s_in[a] = ys[CS_W-1:0];
      end
      m1_in[0] = cs_c_ff[AXIS_YAW] * cs_c_ff[AXIS_ROLL];
      m1_in[1] = cs_c_ff[AXIS_YAW] * cs_s_ff[AXIS_ROLL];
      m1_in[2] = cs_s_ff[AXIS_YAW] * cs_s_ff[AXIS_ROLL];
      m1_in[3] = cs_s_ff[AXIS_YAW] * cs_c_ff[AXIS_ROLL];
      for (int k = 0; k < 4; k++) begin
         av[k] = signed'(m1_ff[k][M1_W-1:14]);
      end
      // av order: w, x, y, z of the yaw * roll product
      m2_in[0] = p2_cp_ff * av[0];
      m2_in[1] = p2_sp_ff * av[2];
      m2_in[2] = p2_cp_ff * av[1];
      m2_in[3] = p2_sp_ff * av[3];
      m2_in[4] = p2_cp_ff * av[2];
      m2_in[5] = p2_sp_ff * av[0];
      m2_in[6] = p2_cp_ff * av[3];
      m2_in[7] = p2_sp_ff * av[1];
      comp4_in[0] = COMP_W'(m2_ff[0] - m2_ff[1]);
      comp4_in[1] = COMP_W'(m2_ff[2] + m2_ff[3]);
      comp4_in[2] = COMP_W'(m2_ff[4] + m2_ff[5]);
      comp4_in[3] = COMP_W'(m2_ff[6] - m2_ff[7]);
      for (int l = 0; l < NUM_COMP; l++) begin
         mag = comp4_ff[l][COMP_W-1] ? COMP_W'(-comp4_ff[l]) : COMP_W'(comp4_ff[l]);
         sq_in[l] = mag * mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_c_ff  <= cs_c_in;
         cs_s_ff  <= cs_s_in;
         m1_ff    <= m1_in;
         p2_cp_ff <= cs_c_ff[AXIS_PITCH];
         p2_sp_ff <= cs_s_ff[AXIS_PITCH];
         m2_ff    <= m2_in;
         comp4_ff <= comp4_in;
         sq_ff    <= sq_in;
         s01_ff   <= sq_ff[0] + sq_ff[1];
         s23_ff   <= sq_ff[2] + sq_ff[3];
         sum_ff   <= s01_ff + s23_ff;
         for (int l = 0; l < NUM_COMP; l++) begin
            comp5_ff[l] <= COMP_W'(comp4_ff[l]);
         end
         comp6_ff <= comp5_ff;
         comp7_ff <= comp6_ff;
      end
   end

   always_comb begin
      schain[0].valid = pv_ff[6];
      schain[0].n     = sum_ff;
      schain[0].res   = '0;
      for (int l = 0; l < NUM_COMP; l++) begin
         schain[0].comp[l] = comp7_ff[l];
      end
   end

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      e2q_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (5'(g)),
         .in_word  (schain[g]),
         .out_word (schain[g+1])
      );
   end

   // dividend is |comp| * 2^14 plus half the root, for rounding
   always_comb begin
      logic [ROOT_W-1:0] r;
      logic [COMP_W-1:0] mag;
      r = schain[SQRT_STEPS].res[ROOT_W-1:0];
      div0_in.valid = schain[SQRT_STEPS].valid;
      div0_in.r     = r;
      div0_in.q     = '0;
      for (int l = 0; l < NUM_COMP; l++) begin
         div0_in.neg[l] = schain[SQRT_STEPS].comp[l][COMP_W-1];
         mag = div0_in.neg[l] ? COMP_W'(-schain[SQRT_STEPS].comp[l])
                              : schain[SQRT_STEPS].comp[l];
         div0_in.rem[l] = REM_W'({mag, 14'b0}) + REM_W'(r >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_ff.valid <= 1'b0;
      end else if (adv) begin
         div0_ff <= div0_in;
      end
   end

   assign dchain[0] = div0_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      e2q_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (4'(DIV_STEPS - 1 - g)),
         .in_word  (dchain[g]),
         .out_word (dchain[g+1])
      );
   end

   // clamp, restore sign; a zero norm gives the identity rotation
   always_comb begin
      logic [Q_W-1:0] q;
      logic [Q_W-1:0] v [NUM_COMP];
      for (int l = 0; l < NUM_COMP; l++) begin
         q = (dchain[DIV_STEPS].q[l] > ONE_Q14) ? ONE_Q14 : dchain[DIV_STEPS].q[l];
         v[l] = dchain[DIV_STEPS].neg[l] ? Q_W'(-q) : q;
      end
      fin_word.quat_w = signed'(v[0]);
      fin_word.quat_x = signed'(v[1]);
      fin_word.quat_y = signed'(v[2]);
      fin_word.quat_z = signed'(v[3]);
      if (dchain[DIV_STEPS].r == '0) begin
         fin_word.quat_w = signed'(ONE_Q14);
         fin_word.quat_x = '0;
         fin_word.quat_y = '0;
         fin_word.quat_z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (skid_vld_ff) begin
         if (!rsp_stall) begin
            rsp_word_ff <= skid_word_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (dchain[DIV_STEPS].valid) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= fin_word;
         end else begin
            skid_vld_ff  <= 1'b1;
            skid_word_ff <= fin_word;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid word held without an output word");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while output was free");

   a_skid_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(dchain[DIV_STEPS]))
      else $error("pipeline moved while skid was full");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.quat_w <= 16'sd16384 && rsp_word_ff.quat_w >= -16'sd16384
                     && rsp_word_ff.quat_x <= 16'sd16384 && rsp_word_ff.quat_x >= -16'sd16384))
      else $error("output component out of range");

endmodule
